@@ rtl/core/particle_momentum_accumulator_core_assert.svh @@
// ----------------------------------------------------------------------------
// particle momentum accumulator assertion macros
// clocked on clk, disabled while rst_n is low
// ----------------------------------------------------------------------------
`ifndef PARTICLE_MOMENTUM_ACCUMULATOR_CORE_ASSERT_SVH
`define PARTICLE_MOMENTUM_ACCUMULATOR_CORE_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define PMA_ASSERT_IMPLIES(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("momentum accumulator assertion failed");

// antecedent implies consequent in the next cycle
`define PMA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("momentum accumulator assertion failed");

`endif

@@ rtl/core/pmacc_pkg.sv @@
// ----------------------------------------------------------------------------
// pmacc_pkg
// widths, register indexes and word types of the momentum accumulator
// ----------------------------------------------------------------------------
package pmacc_pkg;

    // field widths
    localparam int DATA_WIDTH = 16;
    localparam int ACC_WIDTH  = 48;
    localparam int FRAC_BITS  = 8;
    localparam int MASS_W     = 16;
    localparam int ROW_W      = 3 * DATA_WIDTH;

    // derived arithmetic widths
    localparam int LIN_PROD_W = MASS_W + 1 + DATA_WIDTH;
    localparam int LIN_W      = LIN_PROD_W - FRAC_BITS;
    localparam int CROSS_W    = DATA_WIDTH + LIN_W;
    localparam int INER_W     = 2 * DATA_WIDTH;
    localparam int ANG_W      = ((CROSS_W + 1) > (INER_W + 2) ? (CROSS_W + 1) : (INER_W + 2)) + 1;
    localparam int ANG_TERM_W = ANG_W - FRAC_BITS;

    // configuration port
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = ROW_W;

    localparam logic [CFG_INDEX_W-1:0] REG_BODY_MODE = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_MASS      = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_ROW_ZERO  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_ROW_ONE   = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_ROW_TWO   = 3'd4;

    // reset values: unit mass, identity inertia
    localparam logic [MASS_W-1:0] MASS_RESET     = 16'd256;
    localparam logic [ROW_W-1:0]  ROW_ZERO_RESET = 48'd256;
    localparam logic [ROW_W-1:0]  ROW_ONE_RESET  = 48'd16777216;
    localparam logic [ROW_W-1:0]  ROW_TWO_RESET  = 48'd1099511627776;

    // default queue depth between front and back
    localparam int DEF_QUEUE_DEPTH = 4;

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] pos_x;
        logic signed [DATA_WIDTH-1:0] pos_y;
        logic signed [DATA_WIDTH-1:0] pos_z;
        logic signed [DATA_WIDTH-1:0] vel_x;
        logic signed [DATA_WIDTH-1:0] vel_y;
        logic signed [DATA_WIDTH-1:0] vel_z;
        logic signed [DATA_WIDTH-1:0] spin_x;
        logic signed [DATA_WIDTH-1:0] spin_y;
        logic signed [DATA_WIDTH-1:0] spin_z;
        logic                         last_item;
    } in_word_t;

    typedef struct packed {
        logic signed [ACC_WIDTH-1:0] lin_mom_x;
        logic signed [ACC_WIDTH-1:0] lin_mom_y;
        logic signed [ACC_WIDTH-1:0] lin_mom_z;
        logic signed [ACC_WIDTH-1:0] ang_mom_x;
        logic signed [ACC_WIDTH-1:0] ang_mom_y;
        logic signed [ACC_WIDTH-1:0] ang_mom_z;
    } out_word_t;

    // classified item between front and back
    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] pos_x;
        logic signed [DATA_WIDTH-1:0] pos_y;
        logic signed [DATA_WIDTH-1:0] pos_z;
        logic signed [LIN_W-1:0]      lin_x;
        logic signed [LIN_W-1:0]      lin_y;
        logic signed [LIN_W-1:0]      lin_z;
        logic signed [DATA_WIDTH-1:0] spin_x;
        logic signed [DATA_WIDTH-1:0] spin_y;
        logic signed [DATA_WIDTH-1:0] spin_z;
        logic                         last_item;
    } queue_entry_t;

    typedef struct packed {
        logic [ROW_W-1:0] row_two;
        logic [ROW_W-1:0] row_one;
        logic [ROW_W-1:0] row_zero;
    } inertia_t;

endpackage

@@ rtl/core/pmacc_front.sv @@
// ----------------------------------------------------------------------------
// pmacc_front
// config registers, input word intake and linear momentum per item
// ----------------------------------------------------------------------------
module pmacc_front (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [pmacc_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [pmacc_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  pmacc_pkg::in_word_t                  in_data,
    input  logic                                 queue_full,
    output logic                                 push,
    output pmacc_pkg::queue_entry_t              push_data,
    output pmacc_pkg::inertia_t                  inertia
);
    import pmacc_pkg::*;

    logic                          body_mode_reg;
    logic [MASS_W-1:0]             mass_reg;
    logic [ROW_W-1:0]              row_zero_reg;
    logic [ROW_W-1:0]              row_one_reg;
    logic [ROW_W-1:0]              row_two_reg;
    logic signed [MASS_W:0]        mass_s;
    logic signed [DATA_WIDTH-1:0]  vel [3];
    logic signed [LIN_PROD_W-1:0]  lin_prod [3];

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            body_mode_reg <= 1'b0;
            mass_reg      <= MASS_RESET;
            row_zero_reg  <= ROW_ZERO_RESET;
            row_one_reg   <= ROW_ONE_RESET;
            row_two_reg   <= ROW_TWO_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_BODY_MODE: body_mode_reg <= cfg_data[0];
                REG_MASS:      mass_reg      <= cfg_data[MASS_W-1:0];
                REG_ROW_ZERO:  row_zero_reg  <= cfg_data;
                REG_ROW_ONE:   row_one_reg   <= cfg_data;
                REG_ROW_TWO:   row_two_reg   <= cfg_data;
                default:       ;
            endcase
        end
    end

    assign inertia.row_zero = row_zero_reg;
    assign inertia.row_one  = row_one_reg;
    assign inertia.row_two  = row_two_reg;

    // intake: take a word whenever the queue has room
    assign in_stall = queue_full;
    assign push     = in_valid && !queue_full;

    // linear momentum, floored by the fraction bits
    assign mass_s = signed'({1'b0, mass_reg});
    assign vel[0] = in_data.vel_x;
    assign vel[1] = in_data.vel_y;
    assign vel[2] = in_data.vel_z;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            lin_prod[i] = mass_s * vel[i];
        end
    end

    // classify: point particles carry no spin term
    always_comb
    begin
        push_data.pos_x     = in_data.pos_x;
        push_data.pos_y     = in_data.pos_y;
        push_data.pos_z     = in_data.pos_z;
        push_data.lin_x     = lin_prod[0][LIN_PROD_W-1:FRAC_BITS];
        push_data.lin_y     = lin_prod[1][LIN_PROD_W-1:FRAC_BITS];
        push_data.lin_z     = lin_prod[2][LIN_PROD_W-1:FRAC_BITS];
        push_data.spin_x    = body_mode_reg ? in_data.spin_x : '0;
        push_data.spin_y    = body_mode_reg ? in_data.spin_y : '0;
        push_data.spin_z    = body_mode_reg ? in_data.spin_z : '0;
        push_data.last_item = in_data.last_item;
    end

endmodule

@@ rtl/core/pmacc_queue.sv @@
// ----------------------------------------------------------------------------
// pmacc_queue
// short first-in first-out queue between front and back
// ----------------------------------------------------------------------------
module pmacc_queue #(
    parameter int DEPTH = pmacc_pkg::DEF_QUEUE_DEPTH
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     push,
    input  pmacc_pkg::queue_entry_t  push_data,
    output logic                     full,
    input  logic                     pop,
    output pmacc_pkg::queue_entry_t  pop_data,
    output logic                     empty
);
    import pmacc_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    queue_entry_t        slots [DEPTH];
    logic [PTR_W-1:0]    wr_ptr_reg;
    logic [PTR_W-1:0]    rd_ptr_reg;
    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    count_next;
    logic                push_en;
    logic                pop_en;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign push_en  = push && !full;
    assign pop_en   = pop && !empty;
    assign pop_data = slots[rd_ptr_reg];

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push_en)
        begin
            slots[wr_ptr_reg] <= push_data;
        end
    end

    // occupancy
    always_comb
    begin
        case ({push_en, pop_en})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    // pointers wrap at the depth
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push_en)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop_en)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
        end
    end

endmodule

@@ rtl/core/pmacc_back.sv @@
// ----------------------------------------------------------------------------
// pmacc_back
// angular products, term sums and saturating accumulation with output word
// ----------------------------------------------------------------------------
module pmacc_back (
    input  logic                     clk,
    input  logic                     rst_n,
    input  pmacc_pkg::inertia_t      inertia,
    input  logic                     queue_empty,
    output logic                     pop,
    input  pmacc_pkg::queue_entry_t  pop_data,
    output logic                     out_valid,
    input  logic                     out_stall,
    output pmacc_pkg::out_word_t     out_data
);
    import pmacc_pkg::*;

    logic [ROW_W-1:0]               iner_row [3];
    logic signed [DATA_WIDTH-1:0]   spin [3];
    logic signed [CROSS_W-1:0]      cross_comb [6];
    logic signed [INER_W-1:0]       iner_comb [3][3];
    logic signed [ANG_W-1:0]        ang_full [3];
    logic signed [ACC_WIDTH-1:0]    term [6];
    logic signed [ACC_WIDTH-1:0]    acc_next [6];
    logic                           adv;

    // product stage
    logic                           b_valid_reg;
    logic                           b_last_reg;
    logic signed [CROSS_W-1:0]      b_cross_reg [6];
    logic signed [INER_W-1:0]       b_iner_reg [3][3];
    logic signed [LIN_W-1:0]        b_lin_reg [3];

    // term stage
    logic                           c_valid_reg;
    logic                           c_last_reg;
    logic signed [LIN_W-1:0]        c_lin_reg [3];
    logic signed [ANG_TERM_W-1:0]   c_ang_reg [3];

    // accumulators and output word
    logic signed [ACC_WIDTH-1:0]    acc_reg [6];
    logic                           out_valid_reg;
    out_word_t                      out_data_reg;

    function automatic logic signed [ACC_WIDTH-1:0] sat_add(
        input logic signed [ACC_WIDTH-1:0] a,
        input logic signed [ACC_WIDTH-1:0] t
    );
        logic signed [ACC_WIDTH:0] sum;
        logic signed [ACC_WIDTH-1:0] res;
        sum = (ACC_WIDTH + 1)'(a) + (ACC_WIDTH + 1)'(t);
        if (sum[ACC_WIDTH] != sum[ACC_WIDTH-1])
        begin
            res = sum[ACC_WIDTH] ? {1'b1, {(ACC_WIDTH - 1){1'b0}}}
                                 : {1'b0, {(ACC_WIDTH - 1){1'b1}}};
        end
        else
        begin
            res = sum[ACC_WIDTH-1:0];
        end
        return res;
    endfunction

    // the whole pipe holds only while a finished set waits on the output
    assign adv = !(c_valid_reg && c_last_reg && out_valid_reg && out_stall);
    assign pop = adv && !queue_empty;

    assign iner_row[0] = inertia.row_zero;
    assign iner_row[1] = inertia.row_one;
    assign iner_row[2] = inertia.row_two;
    assign spin[0]     = pop_data.spin_x;
    assign spin[1]     = pop_data.spin_y;
    assign spin[2]     = pop_data.spin_z;

    // cross product and inertia products
    always_comb
    begin
        cross_comb[0] = pop_data.pos_y * pop_data.lin_z;
        cross_comb[1] = pop_data.pos_z * pop_data.lin_y;
        cross_comb[2] = pop_data.pos_z * pop_data.lin_x;
        cross_comb[3] = pop_data.pos_x * pop_data.lin_z;
        cross_comb[4] = pop_data.pos_x * pop_data.lin_y;
        cross_comb[5] = pop_data.pos_y * pop_data.lin_x;
        for (int r = 0; r < 3; r++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                iner_comb[r][c] = signed'(iner_row[r][c*DATA_WIDTH +: DATA_WIDTH]) * spin[c];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            b_last_reg <= pop_data.last_item;
            b_cross_reg <= cross_comb;
            b_iner_reg <= iner_comb;
            b_lin_reg[0] <= pop_data.lin_x;
            b_lin_reg[1] <= pop_data.lin_y;
            b_lin_reg[2] <= pop_data.lin_z;
        end
    end

    // exact angular sum, then one floor
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            ang_full[i] = ANG_W'(b_cross_reg[2*i]) - ANG_W'(b_cross_reg[2*i+1])
                        + ANG_W'(b_iner_reg[i][0]) + ANG_W'(b_iner_reg[i][1])
                        + ANG_W'(b_iner_reg[i][2]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            c_last_reg <= b_last_reg;
            c_lin_reg  <= b_lin_reg;
            for (int i = 0; i < 3; i++)
            begin
                c_ang_reg[i] <= ang_full[i][ANG_W-1:FRAC_BITS];
            end
        end
    end

    // saturating accumulate
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            term[i]     = ACC_WIDTH'(c_lin_reg[i]);
            term[3 + i] = ACC_WIDTH'(c_ang_reg[i]);
        end
        for (int k = 0; k < 6; k++)
        begin
            acc_next[k] = sat_add(acc_reg[k], term[k]);
        end
    end

    // control and accumulators
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg   <= 1'b0;
            c_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int k = 0; k < 6; k++)
            begin
                acc_reg[k] <= '0;
            end
        end
        else
        begin
            // a finished set raises the word, an accepted word drops it
            if (adv && c_valid_reg && c_last_reg)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            if (adv)
            begin
                b_valid_reg <= pop;
                c_valid_reg <= b_valid_reg;
                if (c_valid_reg)
                begin
                    if (c_last_reg)
                    begin
                        for (int k = 0; k < 6; k++)
                        begin
                            acc_reg[k] <= '0;
                        end
                    end
                    else
                    begin
                        acc_reg <= acc_next;
                    end
                end
            end
        end
    end

    // output word loads with the totals of the set
    always_ff @(posedge clk)
    begin
        if (adv && c_valid_reg && c_last_reg)
        begin
            out_data_reg.lin_mom_x <= acc_next[0];
            out_data_reg.lin_mom_y <= acc_next[1];
            out_data_reg.lin_mom_z <= acc_next[2];
            out_data_reg.ang_mom_x <= acc_next[3];
            out_data_reg.ang_mom_y <= acc_next[4];
            out_data_reg.ang_mom_z <= acc_next[5];
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

@@ rtl/core/particle_momentum_accumulator_core.sv @@
// ----------------------------------------------------------------------------
// particle_momentum_accumulator_core: linear and angular momentum totals
// path: a last word passes the queue, the product stage, the term stage and the output register
// throughput: 1 word per cycle, except while a finished set waits on a stalled output
// reset: accumulators zero, unit mass, identity inertia, point mode, queue empty
// ----------------------------------------------------------------------------
module particle_momentum_accumulator_core #(
    parameter int QUEUE_DEPTH = pmacc_pkg::DEF_QUEUE_DEPTH
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [pmacc_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [pmacc_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  pmacc_pkg::in_word_t                  in_data,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output pmacc_pkg::out_word_t                 out_data
);
    import pmacc_pkg::*;

    logic          queue_full;
    logic          queue_empty;
    logic          push;
    logic          pop;
    queue_entry_t  push_data;
    queue_entry_t  pop_data;
    inertia_t      inertia;

    // intake and linear momentum
    pmacc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_data    (in_data),
        .queue_full (queue_full),
        .push       (push),
        .push_data  (push_data),
        .inertia    (inertia)
    );

    // decoupling queue
    pmacc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (queue_full),
        .pop       (pop),
        .pop_data  (pop_data),
        .empty     (queue_empty)
    );

    // angular terms and accumulation
    pmacc_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .inertia     (inertia),
        .queue_empty (queue_empty),
        .pop         (pop),
        .pop_data    (pop_data),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_data    (out_data)
    );

endmodule

@@ rtl/core/pmacc_checker.sv @@
// ----------------------------------------------------------------------------
// pmacc_checker
// port level checks of the momentum accumulator, bound to the top level
// ----------------------------------------------------------------------------
`include "particle_momentum_accumulator_core_assert.svh"

module pmacc_checker (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_stall,
    input  logic                  out_valid,
    input  logic                  out_stall,
    input  pmacc_pkg::out_word_t  out_data
);
    import pmacc_pkg::*;

    // a held output word keeps its totals
    `PMA_ASSERT_NEXT(out_hold_a, out_valid && out_stall, out_valid && $stable(out_data))

    // with the output side moving, the queue drains and intake never stalls
    `PMA_ASSERT_IMPLIES(no_back_pressure_a, $past(!out_stall), !in_stall)

    // no totals can appear out of reset before a last word has passed the queue and the back stages
    `PMA_ASSERT_IMPLIES(reset_latency_a, !$past(rst_n, 3), !out_valid)

endmodule

bind particle_momentum_accumulator_core pmacc_checker u_checker (.*);

@@ bench/tb_particle_momentum_accumulator_core.sv @@
// ----------------------------------------------------------------------------
// tb_particle_momentum_accumulator_core
// streams particle words with random gaps and result stalls, keeps its own
// saturating momentum totals and compares every result word field by field
// ----------------------------------------------------------------------------
module tb_particle_momentum_accumulator_core;
    timeunit 1ns;
    timeprecision 1ps;

    import pmacc_pkg::*;

    // indexes past the register list, writes there must change nothing
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_FIRST = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_LAST  = 3'd7;

    localparam longint SUM_MAX = (longint'(1) <<< (ACC_WIDTH - 1)) - 1;
    localparam longint SUM_MIN = -SUM_MAX - 1;

    // coordinate extremes in Q8.8
    localparam logic [DATA_WIDTH-1:0] COORD_MIN = 16'h8000;
    localparam logic [DATA_WIDTH-1:0] COORD_MAX = 16'h7FFF;

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   cfg_we    = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;
    logic                   in_valid  = 1'b0;
    logic                   in_stall;
    in_word_t               in_data   = '0;
    logic                   out_valid;
    logic                   out_stall = 1'b0;
    out_word_t              out_data;

    // predicted register contents and running totals
    bit                rigid_mode;
    logic [MASS_W-1:0] mass_q8;
    logic [ROW_W-1:0]  inertia_row [3];
    longint            running_totals [6];
    out_word_t         expected_totals [$];
    int                errors = 0;

    // idle pattern state for both channels
    bit in_calm       = 1'b0;
    int in_calm_left  = 0;
    bit out_calm      = 1'b0;
    int out_calm_left = 0;
    int stall_left    = 0;

    particle_momentum_accumulator_core uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    // 2 ns clock
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // run limit
    initial
    begin
        #20_000_000;
        $display("simulation failed");
        $finish;
    end

    // ------------------------------------------------------------------------
    // momentum prediction
    // ------------------------------------------------------------------------

    function automatic void reset_registers();
        rigid_mode     = 1'b0;
        mass_q8        = 16'd256;
        inertia_row[0] = 48'd256;
        inertia_row[1] = 48'd16777216;
        inertia_row[2] = 48'd1099511627776;
        for (int i = 0; i < 6; i++)
            running_totals[i] = 0;
    endfunction

    function automatic void apply_register(logic [CFG_INDEX_W-1:0] idx,
                                           logic [CFG_DATA_W-1:0] data);
        case (idx)
            REG_BODY_MODE: rigid_mode     = data[0];
            REG_MASS:      mass_q8        = data[MASS_W-1:0];
            REG_ROW_ZERO:  inertia_row[0] = data;
            REG_ROW_ONE:   inertia_row[1] = data;
            REG_ROW_TWO:   inertia_row[2] = data;
            default: ;
        endcase
    endfunction

    function automatic longint clamp_sum(longint acc, longint term);
        longint s;
        s = acc + term;
        if (s > SUM_MAX)
            s = SUM_MAX;
        else if (s < SUM_MIN)
            s = SUM_MIN;
        return s;
    endfunction

    // add one particle to the totals, queue the totals on a last word
    function automatic void accumulate_momentum(in_word_t w);
        longint                       p [3];
        longint                       v [3];
        longint                       s [3];
        longint                       lin [3];
        longint                       ang [3];
        longint                       m;
        logic signed [DATA_WIDTH-1:0] e;
        out_word_t                    totals;
        p[0] = longint'(w.pos_x);  p[1] = longint'(w.pos_y);  p[2] = longint'(w.pos_z);
        v[0] = longint'(w.vel_x);  v[1] = longint'(w.vel_y);  v[2] = longint'(w.vel_z);
        s[0] = longint'(w.spin_x); s[1] = longint'(w.spin_y); s[2] = longint'(w.spin_z);
        m = longint'(mass_q8);
        // linear momentum, floored back to Q8.8
        for (int i = 0; i < 3; i++)
            lin[i] = (m * v[i]) >>> FRAC_BITS;
        // position cross linear momentum, kept exact until the final shift
        ang[0] = p[1] * lin[2] - p[2] * lin[1];
        ang[1] = p[2] * lin[0] - p[0] * lin[2];
        ang[2] = p[0] * lin[1] - p[1] * lin[0];
        // rigid bodies add inertia times spin
        if (rigid_mode)
        begin
            for (int i = 0; i < 3; i++)
                for (int j = 0; j < 3; j++)
                begin
                    e = inertia_row[i][DATA_WIDTH*j +: DATA_WIDTH];
                    ang[i] += e * s[j];
                end
        end
        for (int i = 0; i < 3; i++)
        begin
            running_totals[i]     = clamp_sum(running_totals[i], lin[i]);
            running_totals[3 + i] = clamp_sum(running_totals[3 + i], ang[i] >>> FRAC_BITS);
        end
        if (w.last_item)
        begin
            totals.lin_mom_x = ACC_WIDTH'(running_totals[0]);
            totals.lin_mom_y = ACC_WIDTH'(running_totals[1]);
            totals.lin_mom_z = ACC_WIDTH'(running_totals[2]);
            totals.ang_mom_x = ACC_WIDTH'(running_totals[3]);
            totals.ang_mom_y = ACC_WIDTH'(running_totals[4]);
            totals.ang_mom_z = ACC_WIDTH'(running_totals[5]);
            expected_totals.insert(expected_totals.size(), totals);
            for (int i = 0; i < 6; i++)
                running_totals[i] = 0;
        end
    endfunction

    // ------------------------------------------------------------------------
    // result checking and result-side stalls
    // ------------------------------------------------------------------------

    function automatic void check_field(string name, logic [ACC_WIDTH-1:0] want,
                                        logic [ACC_WIDTH-1:0] got);
        if (got !== want)
        begin
            $error("%s expected %0d got %0d", name, $signed(want), $signed(got));
            errors++;
        end
    endfunction

    // mostly short idle stretches, a few long ones
    function automatic int pick_idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(4, 24);
    endfunction

    always @(posedge clk)
    begin : result_side
        out_word_t want;
        // compare an accepted result word with the oldest prediction
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_totals.size() == 0)
            begin
                $error("result word with no totals expected");
                errors++;
            end
            else
            begin
                want = expected_totals.pop_front();
                check_field("lin_mom_x", want.lin_mom_x, out_data.lin_mom_x);
                check_field("lin_mom_y", want.lin_mom_y, out_data.lin_mom_y);
                check_field("lin_mom_z", want.lin_mom_z, out_data.lin_mom_z);
                check_field("ang_mom_x", want.ang_mom_x, out_data.ang_mom_x);
                check_field("ang_mom_y", want.ang_mom_y, out_data.ang_mom_y);
                check_field("ang_mom_z", want.ang_mom_z, out_data.ang_mom_z);
            end
        end
        // stall pattern, with calm stretches
        if (!rst_n)
            out_stall <= 1'b0;
        else
        begin
            if (out_calm_left == 0)
            begin
                out_calm      = ($urandom_range(0, 3) == 0);
                out_calm_left = $urandom_range(20, 200);
            end
            else
                out_calm_left--;
            if (stall_left > 0)
            begin
                stall_left--;
                out_stall <= 1'b1;
            end
            else
            begin
                stall_left = out_calm ? 0 : pick_idle_len();
                if (stall_left > 0)
                begin
                    stall_left--;
                    out_stall <= 1'b1;
                end
                else
                    out_stall <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------

    function automatic in_word_t make_word(int px, int py, int pz, int vx, int vy,
                                           int vz, int sx, int sy, int sz, bit last);
        in_word_t w;
        w.pos_x     = px[DATA_WIDTH-1:0];
        w.pos_y     = py[DATA_WIDTH-1:0];
        w.pos_z     = pz[DATA_WIDTH-1:0];
        w.vel_x     = vx[DATA_WIDTH-1:0];
        w.vel_y     = vy[DATA_WIDTH-1:0];
        w.vel_z     = vz[DATA_WIDTH-1:0];
        w.spin_x    = sx[DATA_WIDTH-1:0];
        w.spin_y    = sy[DATA_WIDTH-1:0];
        w.spin_z    = sz[DATA_WIDTH-1:0];
        w.last_item = last;
        return w;
    endfunction

    // coordinate with weight on the extremes, zero and small values
    function automatic logic [DATA_WIDTH-1:0] pick_coord();
        int r;
        int small_val;
        r = $urandom_range(0, 99);
        if (r < 8)
            return COORD_MIN;
        if (r < 16)
            return COORD_MAX;
        if (r < 24)
            return '0;
        if (r < 40)
        begin
            small_val = int'($urandom_range(0, 1023)) - 512;
            return small_val[DATA_WIDTH-1:0];
        end
        return DATA_WIDTH'($urandom);
    endfunction

    function automatic in_word_t random_word();
        in_word_t w;
        w.pos_x     = pick_coord();
        w.pos_y     = pick_coord();
        w.pos_z     = pick_coord();
        w.vel_x     = pick_coord();
        w.vel_y     = pick_coord();
        w.vel_z     = pick_coord();
        w.spin_x    = pick_coord();
        w.spin_y    = pick_coord();
        w.spin_z    = pick_coord();
        w.last_item = ($urandom_range(0, 7) == 0);
        return w;
    endfunction

    function automatic logic [ROW_W-1:0] random_row();
        return {pick_coord(), pick_coord(), pick_coord()};
    endfunction

    // present one word, hold it through stalls, predict once accepted
    task automatic send_word(in_word_t w);
        int gap;
        if (in_calm_left == 0)
        begin
            in_calm      = ($urandom_range(0, 3) == 0);
            in_calm_left = $urandom_range(10, 100);
        end
        else
            in_calm_left--;
        gap = in_calm ? 0 : pick_idle_len();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= w;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        accumulate_momentum(w);
    endtask

    // wait for every result, then for the pipeline to empty
    task automatic drain_and_settle();
        in_valid <= 1'b0;
        while (expected_totals.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_register(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        apply_register(idx, data);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    // unit mass and identity inertia straight out of reset
    task automatic test_reset_state();
        send_word(make_word(256, 0, 0, 0, 256, 0, 100, 200, 300, 1'b0));
        send_word(make_word(0, 512, -256, -256, 0, 128, -5, 7, 9, 1'b1));
        drain_and_settle();
        write_register(REG_BODY_MODE, 48'd1);
        send_word(make_word(128, -128, 64, 3, -3, 1, 256, -512, 768, 1'b0));
        send_word(make_word(0, 0, 0, 0, 0, 0, -32768, 32767, -1, 1'b1));
        drain_and_settle();
    endtask

    // extreme coordinates, full mass, extreme inertia, floor rounding
    task automatic test_field_extremes();
        write_register(REG_MASS, 48'hFFFF);
        write_register(REG_ROW_ZERO, {COORD_MAX, COORD_MIN, COORD_MAX});
        write_register(REG_ROW_ONE, {COORD_MIN, COORD_MAX, COORD_MIN});
        write_register(REG_ROW_TWO, {16'hFFFF, 16'h0001, COORD_MIN});
        send_word(make_word(32767, 32767, 32767, 32767, 32767, 32767,
                            32767, 32767, 32767, 1'b0));
        send_word(make_word(-32768, -32768, -32768, -32768, -32768, -32768,
                            -32768, -32768, -32768, 1'b0));
        send_word(make_word(32767, -32768, 32767, -32768, 32767, -32768,
                            -32768, 32767, -32768, 1'b1));
        // single word sets, small velocities round toward minus infinity
        send_word(make_word(1, -1, 1, -1, 1, -1, 1, -1, 1, 1'b1));
        send_word(make_word(-1, -1, -1, -1, -1, -1, -1, -1, -1, 1'b1));
        send_word(make_word(0, 0, 0, 0, 0, 0, 0, 0, 0, 1'b1));
        drain_and_settle();
        // point mode ignores spin and inertia
        write_register(REG_BODY_MODE, 48'd0);
        send_word(make_word(300, -700, 1200, -1, 2, -3, 32767, -32768, 32767, 1'b0));
        send_word(make_word(-32768, 32767, 0, 32767, -32768, 1, -32768, -32768, -32768, 1'b1));
        drain_and_settle();
    endtask

    // data bits beyond a register width and unused indexes are dropped
    task automatic test_register_masking();
        write_register(REG_BODY_MODE, '1);
        write_register(REG_MASS, 48'hABCD_0000_0180);
        for (int k = REG_SPARE_FIRST; k <= REG_SPARE_LAST; k++)
            write_register(k[CFG_INDEX_W-1:0], CFG_DATA_W'({$urandom, $urandom}));
        send_word(make_word(100, 200, -300, 400, -500, 600, 700, -800, 900, 1'b1));
        drain_and_settle();
        write_register(REG_BODY_MODE, 48'hFFFF_FFFF_FFFE);
        send_word(make_word(-100, 50, 25, 4000, -3000, 2000, 1000, 1000, 1000, 1'b1));
        drain_and_settle();
    endtask

    // long same-sign set builds large angular x and z totals
    task automatic test_saturation();
        in_word_t push_word;
        in_word_t pull_word;
        write_register(REG_BODY_MODE, 48'd0);
        write_register(REG_MASS, 48'hFFFF);
        push_word = make_word(32767, -32768, 32767, -32768, 32767, -32768, 0, 0, 0, 1'b0);
        pull_word = make_word(32767, -32768, 32767, 32767, -32768, 32767, 0, 0, 0, 1'b0);
        repeat (140)
            send_word(push_word);
        // a few words pulling back from the peak, then close the set
        repeat (3)
            send_word(pull_word);
        pull_word.last_item = 1'b1;
        send_word(pull_word);
        // the next set starts from cleared totals
        send_word(make_word(10, 20, 30, 40, 50, 60, 0, 0, 0, 1'b1));
        drain_and_settle();
    endtask

    // phases of random words under changing settings
    task automatic test_random_phases();
        in_word_t w;
        logic [MASS_W-1:0] mass_pick;
        for (int phase = 0; phase < 8; phase++)
        begin
            drain_and_settle();
            write_register(REG_BODY_MODE,
                           CFG_DATA_W'((phase < 4) ? phase % 2 : $urandom_range(0, 1)));
            case (phase)
                0:       mass_pick = '0;
                1:       mass_pick = '1;
                2:       mass_pick = 16'd256;
                default: mass_pick = MASS_W'($urandom);
            endcase
            write_register(REG_MASS, CFG_DATA_W'(mass_pick));
            for (int r = 0; r < 3; r++)
            begin
                case (phase)
                    2:       write_register(CFG_INDEX_W'(REG_ROW_ZERO + r), {3{COORD_MIN}});
                    3:       write_register(CFG_INDEX_W'(REG_ROW_ZERO + r), {3{COORD_MAX}});
                    default: write_register(CFG_INDEX_W'(REG_ROW_ZERO + r), random_row());
                endcase
            end
            for (int n = 0; n < 80; n++)
            begin
                w = random_word();
                if (n == 79)
                    w.last_item = 1'b1;
                send_word(w);
            end
        end
        drain_and_settle();
    endtask

    // ------------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------------

    initial
    begin
        reset_registers();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_state();
        test_field_extremes();
        test_register_masking();
        test_saturation();
        test_random_phases();
        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

@@ particle_momentum_accumulator_core.f @@
+incdir+rtl/core
rtl/core/pmacc_pkg.sv
rtl/core/pmacc_front.sv
rtl/core/pmacc_queue.sv
rtl/core/pmacc_back.sv
rtl/core/particle_momentum_accumulator_core.sv
rtl/core/pmacc_checker.sv
bench/tb_particle_momentum_accumulator_core.sv
